@@ rtl/bitmap_font_text_layout_defines.svh @@
// Assertion macros shared by the bitmap font text layout modules.
// Depends on nothing; a module that uses them must have clk and rst_n in scope.
`ifndef BITMAP_FONT_TEXT_LAYOUT_DEFINES_SVH
`define BITMAP_FONT_TEXT_LAYOUT_DEFINES_SVH
`ifndef SYNTHESIS
`define BFTL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BFTL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BFTL_ASSERT(lbl, prop, msg)
`define BFTL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/bftl_pkg.sv @@
// Package for the bitmap font text layout block: widths, register indexes,
// payload and command types, and the layout engine state type. No dependencies.
`timescale 1ns / 1ps

package bftl_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int COORD_BITS  = 20;

    localparam int CODE_W    = 8;
    localparam int GW_W      = 8;
    localparam int CELL_W_W  = 12;
    localparam int CELL_H_W  = 12;
    localparam int ATLAS_W_W = 13;
    localparam int ATLAS_H_W = 13;
    localparam int FONT_W    = 10;
    localparam int WRAP_W    = 16;

    localparam int SCREEN_W = 20;
    localparam int TEX_X_W  = 13;
    localparam int TEX_Y_W  = 16;

    localparam int OFFSET_W     = CELL_W_W + CODE_W;
    localparam int SCALE_PROD_W = FONT_W + GW_W;
    localparam int PEN_SUM_W    = ((COORD_BITS > SCALE_PROD_W) ? COORD_BITS : SCALE_PROD_W) + 1;

    // Shared divider geometry: wide enough for both the scale and the cell divisions.
    localparam int DIV_N_W       = (OFFSET_W > SCALE_PROD_W) ? OFFSET_W : SCALE_PROD_W;
    localparam int DIV_D_W       = (ATLAS_W_W > CELL_W_W) ? ATLAS_W_W : CELL_W_W;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_CYCLES    = (DIV_N_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_PAD_W     = DIV_CYCLES * DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_TX      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_TY      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT   = CFG_IDX_W'(5);

    localparam logic [CELL_W_W-1:0]  CELL_TX_RST      = CELL_W_W'(16);
    localparam logic [CELL_H_W-1:0]  CELL_TY_RST      = CELL_H_W'(16);
    localparam logic [ATLAS_W_W-1:0] ATLAS_WIDTH_RST  = ATLAS_W_W'(256);
    localparam logic [ATLAS_H_W-1:0] ATLAS_HEIGHT_RST = ATLAS_H_W'(256);
    localparam logic [FONT_W-1:0]    LINE_HEIGHT_RST  = FONT_W'(16);
    localparam logic [WRAP_W-1:0]    WRAP_LIMIT_RST   = WRAP_W'(0);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PLACE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [CODE_W-1:0] char_code;
        logic [GW_W-1:0]   glyph_width;
        logic              first_of_text;
    } in_item_t;

    typedef struct packed {
        logic [SCREEN_W-1:0] screen_left;
        logic [SCREEN_W-1:0] screen_top;
        logic [SCREEN_W-1:0] screen_right;
        logic [SCREEN_W-1:0] screen_bottom;
        logic [TEX_X_W-1:0]  tex_left;
        logic [TEX_Y_W-1:0]  tex_top;
        logic [TEX_X_W-1:0]  tex_right;
        logic [TEX_Y_W-1:0]  tex_bottom;
    } out_item_t;

    typedef struct packed {
        logic [CELL_W_W-1:0]  cell_tx;
        logic [CELL_H_W-1:0]  cell_ty;
        logic [ATLAS_W_W-1:0] atlas_width;
        logic [ATLAS_H_W-1:0] atlas_height;
        logic [FONT_W-1:0]    line_height;
        logic [WRAP_W-1:0]    wrap_limit;
    } cfg_t;

    typedef enum logic {
        CMD_LOAD,
        CMD_PLACE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic                in_table;
        logic                first;
        logic [CODE_W-1:0]   code;
        logic [GW_W-1:0]     glyph_width;
        logic [OFFSET_W-1:0] cell_offset;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_DIVIDE,
        BK_WAIT,
        BK_PEN,
        BK_EMIT
    } back_state_t;

endpackage

@@ rtl/bftl_div.sv @@
// Iterative restoring divider, several quotient bits per cycle.
// Depends on bftl_pkg for its widths and step count.
`timescale 1ns / 1ps

module bftl_div
    import bftl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               busy,
    output logic [DIV_N_W-1:0] quotient,
    output logic [DIV_D_W-1:0] remainder
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_PAD_W-1:0] quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;

    logic [DIV_PAD_W-1:0] quo_w;
    logic [DIV_D_W-1:0]   rem_w;
    logic [DIV_D_W:0]     trial;

    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    always_comb
    begin
        quo_w = quo_reg;
        rem_w = rem_reg;
        trial = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial = {rem_w, quo_w[DIV_PAD_W-1]};
            quo_w = {quo_w[DIV_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial    = trial - {1'b0, den_reg};
                quo_w[0] = 1'b1;
            end
            rem_w = trial[DIV_D_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= DIV_CNT_W'(DIV_CYCLES);
        end
        else if (busy_reg)
        begin
            busy_reg  <= (count_reg != DIV_CNT_W'(1));
            count_reg <= count_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            quo_reg <= DIV_PAD_W'(dividend);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_w;
            rem_reg <= rem_w;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg[DIV_N_W-1:0];
    assign remainder = rem_reg;

endmodule

@@ rtl/bftl_fifo.sv @@
// Short command queue between the front end and the layout engine.
// Depends on bftl_pkg for the command type and the queue depth.
`timescale 1ns / 1ps
`include "bitmap_font_text_layout_defines.svh"

module bftl_fifo
    import bftl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] ptr);
        logic [QUEUE_PTR_W-1:0] nxt;
        if (ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = ptr + QUEUE_PTR_W'(1);
        end
        return nxt;
    endfunction

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `BFTL_ASSERT(a_fifo_no_overflow, !(push && full), "command pushed into a full queue")
    `BFTL_ASSERT(a_fifo_no_underflow, !(pop && empty), "command popped from an empty queue")
    `BFTL_ASSERT(a_fifo_count_range, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

@@ rtl/bftl_front.sv @@
// Front end: accepts input transactions, classifies them into commands and
// works out the atlas cell offset. Depends on bftl_pkg.
`timescale 1ns / 1ps

module bftl_front
    import bftl_pkg::*;
(
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     fifo_full,
    output logic     push,
    output cmd_t     push_cmd
);

    logic in_table;
    logic drop;

    assign in_table = (32'(in_data.char_code) < GLYPH_COUNT);
    // A load aimed beyond the glyph table changes nothing, so it never enters the queue.
    assign drop     = (in_data.req_type == REQ_LOAD) && !in_table;
    assign in_ready = !fifo_full;
    assign push     = in_valid && in_ready && !drop;

    always_comb
    begin
        push_cmd.op          = (in_data.req_type == REQ_PLACE) ? CMD_PLACE : CMD_LOAD;
        push_cmd.in_table    = in_table;
        push_cmd.first       = in_data.first_of_text;
        push_cmd.code        = in_data.char_code;
        push_cmd.glyph_width = in_data.glyph_width;
        push_cmd.cell_offset = OFFSET_W'(in_data.char_code) * OFFSET_W'(cfg.cell_tx);
    end

endmodule

@@ rtl/bftl_back.sv @@
// Layout engine: glyph width table, the two divisions, pen update and the
// output register. Depends on bftl_pkg and bftl_div.
`timescale 1ns / 1ps
`include "bitmap_font_text_layout_defines.svh"

module bftl_back
    import bftl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      head,
    input  logic      fifo_empty,
    output logic      fifo_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [GW_W-1:0]         glyph_mem [GLYPH_COUNT];
    logic [GLYPH_COUNT-1:0]  glyph_valid_reg;
    logic [GW_W-1:0]         rd_data_reg;
    logic                    rd_valid_reg;
    logic [GLYPH_IDX_W-1:0]  head_idx;

    cmd_t                    cmd_reg;
    logic [GW_W-1:0]         w_reg;
    logic [SCALE_PROD_W-1:0] prod_reg;
    logic [SCALE_PROD_W-1:0] scaled_reg;
    logic [COORD_BITS-1:0]   x0_reg;
    logic [COORD_BITS-1:0]   y0_reg;
    logic [TEX_X_W-1:0]      cx_reg;
    logic [TEX_Y_W-1:0]      cy_reg;
    logic [COORD_BITS-1:0]   pen_x_reg;
    logic [COORD_BITS-1:0]   pen_y_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic                    load_wr;
    logic                    place_take;
    logic                    div_start;
    logic                    out_free;
    logic                    emit;

    logic                    div_s_busy;
    logic                    div_a_busy;
    logic [DIV_N_W-1:0]      quo_s;
    logic [DIV_N_W-1:0]      quo_a;
    logic [DIV_D_W-1:0]      rem_a;

    logic [GW_W-1:0]         w_lookup;
    logic [COORD_BITS-1:0]   px;
    logic [COORD_BITS-1:0]   py;
    logic [SCALE_PROD_W-1:0] scaled_w;
    logic [PEN_SUM_W-1:0]    pen_sum;
    logic                    wrap;
    logic [COORD_BITS-1:0]   y_wrap;
    logic [TEX_Y_W-1:0]      cy_w;
    logic [COORD_BITS-1:0]   right_w;
    logic [COORD_BITS-1:0]   bottom_w;
    logic [TEX_X_W-1:0]      tex_right_w;
    logic [TEX_Y_W-1:0]      tex_bottom_w;

    assign head_idx = head.code[GLYPH_IDX_W-1:0];
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty && (head.op == CMD_PLACE))
                begin
                    state_next = BK_LOOKUP;
                end
            end
            BK_LOOKUP: state_next = BK_DIVIDE;
            BK_DIVIDE: state_next = BK_WAIT;
            BK_WAIT:
            begin
                if (!div_s_busy && !div_a_busy)
                begin
                    state_next = BK_PEN;
                end
            end
            BK_PEN: state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        load_wr    = 1'b0;
        place_take = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                load_wr    = !fifo_empty && (head.op == CMD_LOAD);
                place_take = !fifo_empty && (head.op == CMD_PLACE);
            end
            BK_DIVIDE: div_start = 1'b1;
            BK_EMIT:   emit      = out_free;
            default:
            begin
                load_wr = 1'b0;
            end
        endcase
    end

    assign fifo_pop = load_wr || place_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Glyph width table: a never-written entry reads as zero through its valid bit.
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            glyph_mem[head_idx] <= head.glyph_width;
        end
        if (place_take)
        begin
            rd_data_reg <= glyph_mem[head_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_valid_reg <= '0;
        end
        else if (load_wr)
        begin
            glyph_valid_reg[head_idx] <= 1'b1;
        end
    end

    bftl_div u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (DIV_N_W'(prod_reg)),
        .divisor   (DIV_D_W'(cfg.cell_tx)),
        .busy      (div_s_busy),
        .quotient  (quo_s),
        .remainder ()
    );

    bftl_div u_div_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (DIV_N_W'(cmd_reg.cell_offset)),
        .divisor   (DIV_D_W'(cfg.atlas_width)),
        .busy      (div_a_busy),
        .quotient  (quo_a),
        .remainder (rem_a)
    );

    always_comb
    begin
        w_lookup = (cmd_reg.in_table && rd_valid_reg) ? rd_data_reg : '0;
        px       = cmd_reg.first ? '0 : pen_x_reg;
        py       = cmd_reg.first ? '0 : pen_y_reg;
        scaled_w = (cfg.cell_tx != '0) ? quo_s[SCALE_PROD_W-1:0] : '0;
        // The wrap test sees the full sum, before any wrap of the pen.
        pen_sum  = PEN_SUM_W'(px) + PEN_SUM_W'(scaled_w);
        wrap     = (cfg.wrap_limit != '0) && (pen_sum > PEN_SUM_W'(cfg.wrap_limit));
        y_wrap   = py + COORD_BITS'(cfg.line_height);
        if (cfg.atlas_width != '0)
        begin
            cy_w = TEX_Y_W'(quo_a[TEX_Y_W-1:0]) * TEX_Y_W'(cfg.cell_ty);
        end
        else
        begin
            cy_w = '0;
        end
        right_w      = x0_reg + COORD_BITS'(scaled_reg);
        bottom_w     = y0_reg + COORD_BITS'(cfg.line_height);
        tex_right_w  = cx_reg + TEX_X_W'(w_reg);
        tex_bottom_w = cy_reg + TEX_Y_W'(cfg.cell_ty);
    end

    always_ff @(posedge clk)
    begin
        if (place_take)
        begin
            cmd_reg      <= head;
            rd_valid_reg <= glyph_valid_reg[head_idx];
        end
        if (state_reg == BK_LOOKUP)
        begin
            w_reg    <= w_lookup;
            prod_reg <= SCALE_PROD_W'(cfg.line_height) * SCALE_PROD_W'(w_lookup);
        end
        if (state_reg == BK_PEN)
        begin
            scaled_reg <= scaled_w;
            x0_reg     <= wrap ? '0 : px;
            y0_reg     <= wrap ? y_wrap : py;
            cx_reg     <= (cfg.atlas_width != '0) ? rem_a[TEX_X_W-1:0]
                                                  : cmd_reg.cell_offset[TEX_X_W-1:0];
            cy_reg     <= cy_w;
        end
        if (emit)
        begin
            out_data_reg.screen_left   <= SCREEN_W'(x0_reg);
            out_data_reg.screen_top    <= SCREEN_W'(y0_reg);
            out_data_reg.screen_right  <= SCREEN_W'(right_w);
            out_data_reg.screen_bottom <= SCREEN_W'(bottom_w);
            out_data_reg.tex_left      <= cx_reg;
            out_data_reg.tex_top       <= cy_reg;
            out_data_reg.tex_right     <= tex_right_w;
            out_data_reg.tex_bottom    <= tex_bottom_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                pen_x_reg     <= right_w;
                pen_y_reg     <= y0_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BFTL_ASSERT(a_div_lockstep, div_s_busy == div_a_busy, "dividers out of step")
    `BFTL_ASSERT(a_out_from_emit,
        $rose(out_valid_reg) |-> $past(state_reg == BK_EMIT),
        "result raised outside the emit step")
    `BFTL_ASSERT(a_pen_hold,
        !$past(state_reg == BK_EMIT) |-> ($stable(pen_x_reg) && $stable(pen_y_reg)),
        "pen moved outside the emit step")

endmodule

@@ rtl/bitmap_font_text_layout.sv @@
// Bitmap font text layout: top level with configuration registers, front end,
// command queue and layout engine. Depends on bftl_pkg and the bftl_* modules.
// A load transaction is written in the engine's idle state; a place transaction
// steps through the lookup, divide, wait, pen and emit states, waiting on the two
// dividers (4 quotient bits a cycle) and, in emit, on a free output register.
// Reset restores register defaults, puts the pen at the origin and clears the
// glyph table at once through per-entry valid bits; no clearing pass.
`timescale 1ns / 1ps

module bitmap_font_text_layout
    import bftl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_push;
    logic fifo_pop;
    cmd_t push_cmd;
    cmd_t head;

    assign cfg_ready = 1'b1;

    // Writes to an index beyond the register list complete but change nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_tx      <= CELL_TX_RST;
            cfg_reg.cell_ty      <= CELL_TY_RST;
            cfg_reg.atlas_width  <= ATLAS_WIDTH_RST;
            cfg_reg.atlas_height <= ATLAS_HEIGHT_RST;
            cfg_reg.line_height  <= LINE_HEIGHT_RST;
            cfg_reg.wrap_limit   <= WRAP_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CELL_TX:      cfg_reg.cell_tx      <= cfg_data[CELL_W_W-1:0];
                CFG_CELL_TY:      cfg_reg.cell_ty      <= cfg_data[CELL_H_W-1:0];
                CFG_ATLAS_WIDTH:  cfg_reg.atlas_width  <= cfg_data[ATLAS_W_W-1:0];
                CFG_ATLAS_HEIGHT: cfg_reg.atlas_height <= cfg_data[ATLAS_H_W-1:0];
                CFG_LINE_HEIGHT:  cfg_reg.line_height  <= cfg_data[FONT_W-1:0];
                CFG_WRAP_LIMIT:   cfg_reg.wrap_limit   <= cfg_data[WRAP_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    bftl_front u_front (
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .fifo_full (fifo_full),
        .push      (fifo_push),
        .push_cmd  (push_cmd)
    );

    bftl_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .head     (head),
        .empty    (fifo_empty)
    );

    bftl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .fifo_empty (fifo_empty),
        .fifo_pop   (fifo_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
